FILE: hdl/ffba_pkg.sv
// package for the first-fit block allocator: constants, codes, table entry and states
`timescale 1ns / 1ps
`default_nettype none
package ffba_pkg;

   localparam int POOL_BYTES   = 4096;
   localparam int MAX_BLOCKS   = 128;
   localparam int HEADER_BYTES = 24;
   localparam int ALIGN_BYTES  = 8;
   localparam int RESET_POOL   = 1024;

   localparam int ADDR_W  = 12;
   localparam int SIZE_W  = 13;
   localparam int NEED_W  = 14;
   localparam int IDX_W   = $clog2(MAX_BLOCKS);
   localparam int COUNT_W = IDX_W + 1;
   localparam int SUM_W   = 32;

   typedef enum logic [0:0] {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } command_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_ZERO_SIZE   = 3'd1,
      ST_OUT_OF_MEM  = 3'd2,
      ST_BAD_ADDRESS = 3'd3,
      ST_DOUBLE_FREE = 3'd4
   } status_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [SIZE_W-1:0] size;
      logic              free;
   } entry_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_SRD,
      S_SCHK,
      S_PRD,
      S_PCHK,
      S_NRD,
      S_NCHK,
      S_MERGE,
      S_MVR,
      S_MVW,
      S_SPL1,
      S_SPL2,
      S_DONE
   } state_type;

endpackage
`default_nettype wire

FILE: hdl/first_fit_block_allocator.sv
// first-fit block allocator with coalescing, block table in one synchronous memory
//
//   channel | direction | words
//   req_    | in        | command, request size, block address
//   rsp_    | out       | status, payload address, block bytes, totals
//   csr_    | in        | pool size write, no read-back
//
// one word at a time; the search visits the table entries in turn, each with one memory
// read and one check, and a split or a merge shifts the table, one read and one write per
// entry moved. the single read and single write port of the table set this. reset and
// every pool size write rebuild entry 0 in the init state.
// a finished word waits in the output register; the next request is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_block_allocator (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_write_enable,
   input  wire logic [ffba_pkg::SIZE_W-1:0]  csr_write_data,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_command,
   input  wire logic [ffba_pkg::SIZE_W-1:0]  req_request_size,
   input  wire logic [ffba_pkg::ADDR_W-1:0]  req_block_address,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [2:0]                        rsp_status,
   output logic [ffba_pkg::ADDR_W-1:0]       rsp_payload_address,
   output logic [ffba_pkg::SIZE_W-1:0]       rsp_block_bytes,
   output logic [ffba_pkg::SUM_W-1:0]        rsp_allocated_total,
   output logic [ffba_pkg::SUM_W-1:0]        rsp_freed_total
);

   localparam logic [ffba_pkg::SIZE_W-1:0] HDR = ffba_pkg::SIZE_W'(ffba_pkg::HEADER_BYTES);
   localparam logic [ffba_pkg::NEED_W-1:0] HDR_N = ffba_pkg::NEED_W'(ffba_pkg::HEADER_BYTES);
   localparam logic [ffba_pkg::COUNT_W-1:0] CNT_MAX =
      ffba_pkg::COUNT_W'(ffba_pkg::MAX_BLOCKS);

   ffba_pkg::entry_type mem [ffba_pkg::MAX_BLOCKS];
   ffba_pkg::entry_type rdata_ff;
   logic                           mem_we;
   logic [ffba_pkg::IDX_W-1:0]     mem_waddr, mem_raddr;
   ffba_pkg::entry_type            mem_wdata;

   ffba_pkg::state_type            state_ff, state_in;
   logic [ffba_pkg::SIZE_W-1:0]    pool_ff, pool_in;
   logic [ffba_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic [ffba_pkg::SUM_W-1:0]     granted_ff, granted_in, released_ff, released_in;
   ffba_pkg::command_type          cmd_ff, cmd_in;
   logic [ffba_pkg::NEED_W-1:0]    need_ff, need_in;
   logic [ffba_pkg::ADDR_W-1:0]    addr_ff, addr_in;
   logic [ffba_pkg::COUNT_W-1:0]   idx_ff, idx_in;
   ffba_pkg::entry_type            fnd_ff, fnd_in, prev_ff, prev_in, nxt_ff, nxt_in;
   logic [ffba_pkg::IDX_W-1:0]     mv_dst_ff, mv_dst_in, mv_last_ff, mv_last_in;
   logic [1:0]                     mv_gap_ff, mv_gap_in;
   logic                           mv_down_ff, mv_down_in;
   ffba_pkg::status_type           res_status_ff, res_status_in;
   logic [ffba_pkg::SIZE_W-1:0]    res_bytes_ff, res_bytes_in;
   logic [ffba_pkg::ADDR_W-1:0]    res_payload_ff, res_payload_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [2:0]                     rsp_status_ff, rsp_status_in;
   logic [ffba_pkg::ADDR_W-1:0]    rsp_payload_ff, rsp_payload_in;
   logic [ffba_pkg::SIZE_W-1:0]    rsp_bytes_ff, rsp_bytes_in;
   logic [ffba_pkg::SUM_W-1:0]     rsp_alloc_ff, rsp_alloc_in, rsp_freed_ff, rsp_freed_in;

   logic [ffba_pkg::SIZE_W-1:0]    pool_clamped;
   logic [ffba_pkg::NEED_W-1:0]    req_round;
   logic [ffba_pkg::ADDR_W:0]      rd_payload;
   logic [ffba_pkg::SUM_W:0]       grant_sum, release_sum;
   logic [ffba_pkg::COUNT_W-1:0]   idx_p1, idx_p2, rm_k;
   logic [1:0]                     rm_g;

   // table memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[mem_raddr];
   end

   always_comb begin
      if (csr_write_data < HDR) begin
         pool_clamped = HDR;
      end else if (csr_write_data > ffba_pkg::SIZE_W'(ffba_pkg::POOL_BYTES)) begin
         pool_clamped = ffba_pkg::SIZE_W'(ffba_pkg::POOL_BYTES);
      end else begin
         pool_clamped = csr_write_data;
      end
   end

   // round up to the alignment
   assign req_round = (ffba_pkg::NEED_W'(req_request_size) +
                       ffba_pkg::NEED_W'(ffba_pkg::ALIGN_BYTES - 1)) &
                      ~ffba_pkg::NEED_W'(ffba_pkg::ALIGN_BYTES - 1);
   assign rd_payload  = {1'b0, rdata_ff.start} + (ffba_pkg::ADDR_W + 1)'(ffba_pkg::HEADER_BYTES);
   assign idx_p1      = idx_ff + 1'b1;
   assign idx_p2      = idx_ff + 2'd2;
   assign grant_sum   = {1'b0, granted_ff} + (ffba_pkg::SUM_W + 1)'(need_ff);
   assign release_sum = {1'b0, released_ff} + (ffba_pkg::SUM_W + 1)'(res_bytes_ff);

   assign req_ready = (state_ff == ffba_pkg::S_IDLE);

   always_comb begin
      state_in       = state_ff;
      pool_in        = pool_ff;
      count_in       = count_ff;
      granted_in     = granted_ff;
      released_in    = released_ff;
      cmd_in         = cmd_ff;
      need_in        = need_ff;
      addr_in        = addr_ff;
      idx_in         = idx_ff;
      fnd_in         = fnd_ff;
      prev_in        = prev_ff;
      nxt_in         = nxt_ff;
      mv_dst_in      = mv_dst_ff;
      mv_last_in     = mv_last_ff;
      mv_gap_in      = mv_gap_ff;
      mv_down_in     = mv_down_ff;
      res_status_in  = res_status_ff;
      res_bytes_in   = res_bytes_ff;
      res_payload_in = res_payload_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_bytes_in   = rsp_bytes_ff;
      rsp_alloc_in   = rsp_alloc_ff;
      rsp_freed_in   = rsp_freed_ff;
      mem_we         = 1'b0;
      mem_waddr      = idx_ff[ffba_pkg::IDX_W-1:0];
      mem_wdata      = rdata_ff;
      mem_raddr      = idx_ff[ffba_pkg::IDX_W-1:0];
      rm_k           = '0;
      rm_g           = '0;

      unique case (state_ff)
         ffba_pkg::S_INIT: begin
            mem_we         = 1'b1;
            mem_waddr      = '0;
            mem_wdata      = '{start: '0, size: pool_ff - HDR, free: 1'b1};
            state_in       = ffba_pkg::S_IDLE;
         end
         ffba_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd_in         = ffba_pkg::command_type'(req_command);
               need_in        = req_round;
               addr_in        = req_block_address;
               idx_in         = '0;
               res_payload_in = '0;
               res_bytes_in   = '0;
               if (req_command == ffba_pkg::CMD_ALLOC && req_request_size == '0) begin
                  res_status_in = ffba_pkg::ST_ZERO_SIZE;
                  state_in      = ffba_pkg::S_DONE;
               end else if (req_command == ffba_pkg::CMD_FREE && req_block_address == '0) begin
                  res_status_in = ffba_pkg::ST_BAD_ADDRESS;
                  state_in      = ffba_pkg::S_DONE;
               end else begin
                  state_in = ffba_pkg::S_SRD;
               end
            end
         end
         ffba_pkg::S_SRD: begin
            if (idx_ff == count_ff) begin
               res_status_in = (cmd_ff == ffba_pkg::CMD_ALLOC) ? ffba_pkg::ST_OUT_OF_MEM
                                                              : ffba_pkg::ST_BAD_ADDRESS;
               state_in      = ffba_pkg::S_DONE;
            end else begin
               state_in = ffba_pkg::S_SCHK;
            end
         end
         ffba_pkg::S_SCHK: begin
            fnd_in   = rdata_ff;
            idx_in   = idx_p1;
            state_in = ffba_pkg::S_SRD;
            if (cmd_ff == ffba_pkg::CMD_ALLOC) begin
               if (rdata_ff.free && ffba_pkg::NEED_W'(rdata_ff.size) >= need_ff) begin
                  idx_in         = idx_ff;
                  res_status_in  = ffba_pkg::ST_OK;
                  res_payload_in = rd_payload[ffba_pkg::ADDR_W-1:0];
                  res_bytes_in   = need_ff[ffba_pkg::SIZE_W-1:0];
                  if (ffba_pkg::NEED_W'(rdata_ff.size) > need_ff + HDR_N &&
                      count_ff != CNT_MAX) begin
                     if (count_ff >= idx_p2) begin
                        // open a gap at the next entry
                        mv_dst_in  = count_ff[ffba_pkg::IDX_W-1:0];
                        mv_last_in = idx_p2[ffba_pkg::IDX_W-1:0];
                        mv_down_in = 1'b1;
                        state_in   = ffba_pkg::S_MVR;
                     end else begin
                        state_in = ffba_pkg::S_SPL1;
                     end
                  end else begin
                     mem_we    = 1'b1;
                     mem_wdata = '{start: rdata_ff.start, size: rdata_ff.size, free: 1'b0};
                     state_in  = ffba_pkg::S_DONE;
                  end
               end
            end else if (rd_payload == {1'b0, addr_ff}) begin
               idx_in = idx_ff;
               if (rdata_ff.free) begin
                  res_status_in = ffba_pkg::ST_DOUBLE_FREE;
                  state_in      = ffba_pkg::S_DONE;
               end else begin
                  res_status_in = ffba_pkg::ST_OK;
                  res_bytes_in  = rdata_ff.size;
                  mem_we        = 1'b1;
                  mem_wdata     = '{start: rdata_ff.start, size: rdata_ff.size, free: 1'b1};
                  prev_in.free  = 1'b0;
                  nxt_in.free   = 1'b0;
                  if (idx_ff != '0) begin
                     state_in = ffba_pkg::S_PRD;
                  end else if (idx_p1 < count_ff) begin
                     state_in = ffba_pkg::S_NRD;
                  end else begin
                     state_in = ffba_pkg::S_DONE;
                  end
               end
            end
         end
         ffba_pkg::S_PRD: begin
            mem_raddr = idx_ff[ffba_pkg::IDX_W-1:0] - 1'b1;
            state_in  = ffba_pkg::S_PCHK;
         end
         ffba_pkg::S_PCHK: begin
            prev_in  = rdata_ff;
            state_in = (idx_p1 < count_ff) ? ffba_pkg::S_NRD : ffba_pkg::S_MERGE;
         end
         ffba_pkg::S_NRD: begin
            mem_raddr = idx_p1[ffba_pkg::IDX_W-1:0];
            state_in  = ffba_pkg::S_NCHK;
         end
         ffba_pkg::S_NCHK: begin
            nxt_in   = rdata_ff;
            state_in = ffba_pkg::S_MERGE;
         end
         ffba_pkg::S_MERGE: begin
            // no two neighboring entries are free before this, so one merge with the free neighbors covers it
            mem_we = prev_ff.free | nxt_ff.free;
            if (prev_ff.free) begin
               mem_waddr = idx_ff[ffba_pkg::IDX_W-1:0] - 1'b1;
               mem_wdata = '{start: prev_ff.start,
                             size: nxt_ff.free ? prev_ff.size + HDR + fnd_ff.size + HDR + nxt_ff.size
                                               : prev_ff.size + HDR + fnd_ff.size,
                             free: 1'b1};
               rm_k      = idx_ff;
               rm_g      = nxt_ff.free ? 2'd2 : 2'd1;
            end else begin
               mem_wdata = '{start: fnd_ff.start, size: fnd_ff.size + HDR + nxt_ff.size,
                             free: 1'b1};
               rm_k      = idx_p1;
               rm_g      = {1'b0, nxt_ff.free};
            end
            count_in   = count_ff - ffba_pkg::COUNT_W'(rm_g);
            mv_dst_in  = rm_k[ffba_pkg::IDX_W-1:0];
            mv_last_in = ffba_pkg::IDX_W'(count_ff - ffba_pkg::COUNT_W'(rm_g) - 1'b1);
            mv_gap_in  = rm_g;
            mv_down_in = 1'b0;
            if (rm_g != '0 && rm_k + ffba_pkg::COUNT_W'(rm_g) < count_ff) begin
               state_in = ffba_pkg::S_MVR;
            end else begin
               state_in = ffba_pkg::S_DONE;
            end
         end
         ffba_pkg::S_MVR: begin
            mem_raddr = mv_down_ff ? mv_dst_ff - 1'b1 : mv_dst_ff + ffba_pkg::IDX_W'(mv_gap_ff);
            state_in  = ffba_pkg::S_MVW;
         end
         ffba_pkg::S_MVW: begin
            mem_we    = 1'b1;
            mem_waddr = mv_dst_ff;
            mem_wdata = rdata_ff;
            if (mv_dst_ff == mv_last_ff) begin
               state_in = mv_down_ff ? ffba_pkg::S_SPL1 : ffba_pkg::S_DONE;
            end else begin
               mv_dst_in = mv_down_ff ? mv_dst_ff - 1'b1 : mv_dst_ff + 1'b1;
               state_in  = ffba_pkg::S_MVR;
            end
         end
         ffba_pkg::S_SPL1: begin
            mem_we    = 1'b1;
            mem_waddr = idx_p1[ffba_pkg::IDX_W-1:0];
            mem_wdata = '{start: fnd_ff.start + ffba_pkg::ADDR_W'(HDR) +
                                 need_ff[ffba_pkg::ADDR_W-1:0],
                          size: fnd_ff.size - need_ff[ffba_pkg::SIZE_W-1:0] - HDR,
                          free: 1'b1};
            state_in  = ffba_pkg::S_SPL2;
         end
         ffba_pkg::S_SPL2: begin
            mem_we    = 1'b1;
            mem_wdata = '{start: fnd_ff.start, size: need_ff[ffba_pkg::SIZE_W-1:0], free: 1'b0};
            count_in  = count_ff + 1'b1;
            state_in  = ffba_pkg::S_DONE;
         end
         ffba_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               if (res_status_ff == ffba_pkg::ST_OK) begin
                  if (cmd_ff == ffba_pkg::CMD_ALLOC) begin
                     granted_in = grant_sum[ffba_pkg::SUM_W] ? '1 : grant_sum[ffba_pkg::SUM_W-1:0];
                  end else begin
                     released_in = release_sum[ffba_pkg::SUM_W] ? '1
                                                               : release_sum[ffba_pkg::SUM_W-1:0];
                  end
               end
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_payload_in = res_payload_ff;
               rsp_bytes_in   = res_bytes_ff;
               rsp_alloc_in   = granted_in;
               rsp_freed_in   = released_in;
               state_in       = ffba_pkg::S_IDLE;
            end
         end
         default: state_in = ffba_pkg::S_IDLE;
      endcase

      // a pool write rebuilds the table; the user must write it only while idle, the block does not enforce this
      if (csr_write_enable) begin
         pool_in     = pool_clamped;
         count_in    = ffba_pkg::COUNT_W'(1);
         granted_in  = '0;
         released_in = '0;
         state_in    = ffba_pkg::S_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffba_pkg::S_INIT;
         pool_ff      <= ffba_pkg::SIZE_W'(ffba_pkg::RESET_POOL);
         count_ff     <= ffba_pkg::COUNT_W'(1);
         granted_ff   <= '0;
         released_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pool_ff      <= pool_in;
         count_ff     <= count_in;
         granted_ff   <= granted_in;
         released_ff  <= released_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      need_ff        <= need_in;
      addr_ff        <= addr_in;
      idx_ff         <= idx_in;
      fnd_ff         <= fnd_in;
      prev_ff        <= prev_in;
      nxt_ff         <= nxt_in;
      mv_dst_ff      <= mv_dst_in;
      mv_last_ff     <= mv_last_in;
      mv_gap_ff      <= mv_gap_in;
      mv_down_ff     <= mv_down_in;
      res_status_ff  <= res_status_in;
      res_bytes_ff   <= res_bytes_in;
      res_payload_ff <= res_payload_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_bytes_ff   <= rsp_bytes_in;
      rsp_alloc_ff   <= rsp_alloc_in;
      rsp_freed_ff   <= rsp_freed_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_payload_address = rsp_payload_ff;
   assign rsp_block_bytes     = rsp_bytes_ff;
   assign rsp_allocated_total = rsp_alloc_ff;
   assign rsp_freed_total     = rsp_freed_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 && count_ff <= CNT_MAX)
      else $error("block count out of range");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ffba_pkg::S_IDLE |-> !mem_we)
      else $error("table written while idle");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !csr_write_enable |=> state_ff != ffba_pkg::S_IDLE)
      else $error("accepted word not worked on");

   a_totals_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(csr_write_enable) && !$past(reset) |->
      granted_ff >= $past(granted_ff) && released_ff >= $past(released_ff))
      else $error("total went down");

endmodule
`default_nettype wire

FILE: tb/sv/first_fit_block_allocator_checker.sv
// checker for the first-fit block allocator: table predictor and response scoreboard
`timescale 1ns / 1ps
module first_fit_block_allocator_checker
   import ffba_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write_enable,
   input  wire logic [SIZE_W-1:0] csr_write_data,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire logic              req_command,
   input  wire logic [SIZE_W-1:0] req_request_size,
   input  wire logic [ADDR_W-1:0] req_block_address,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire logic [2:0]        rsp_status,
   input  wire logic [ADDR_W-1:0] rsp_payload_address,
   input  wire logic [SIZE_W-1:0] rsp_block_bytes,
   input  wire logic [SUM_W-1:0]  rsp_allocated_total,
   input  wire logic [SUM_W-1:0]  rsp_freed_total,
   output int                     fail_count,
   output int                     pending
);

   typedef struct packed {
      status_type        status;
      logic [ADDR_W-1:0] payload;
      logic [SIZE_W-1:0] bytes;
      logic [SUM_W-1:0]  granted;
      logic [SUM_W-1:0]  released;
   } outcome_type;

   int unsigned blk_start [MAX_BLOCKS];
   int unsigned blk_size  [MAX_BLOCKS];
   bit          blk_free  [MAX_BLOCKS];
   int unsigned blk_count;
   logic [SUM_W-1:0] granted_bytes;
   logic [SUM_W-1:0] released_bytes;
   outcome_type outcome_queue[$];

   function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] a, int unsigned b);
      logic [SUM_W:0] s;
      s = {1'b0, a} + b;
      return s[SUM_W] ? '1 : s[SUM_W-1:0];
   endfunction

   function automatic void rebuild_pool(int unsigned requested);
      int unsigned p;
      p = requested;
      if (p < HEADER_BYTES) p = HEADER_BYTES;
      if (p > POOL_BYTES) p = POOL_BYTES;
      for (int i = 0; i < MAX_BLOCKS; i++) begin
         blk_start[i] = 0;
         blk_size[i]  = 0;
         blk_free[i]  = 0;
      end
      blk_size[0]    = p - HEADER_BYTES;
      blk_free[0]    = 1;
      blk_count      = 1;
      granted_bytes  = '0;
      released_bytes = '0;
   endfunction

   function automatic void drop_entry(int unsigned k);
      for (int unsigned j = k; j + 1 < blk_count; j++) begin
         blk_start[j] = blk_start[j+1];
         blk_size[j]  = blk_size[j+1];
         blk_free[j]  = blk_free[j+1];
      end
      blk_count--;
   endfunction

   function automatic outcome_type allocate_or_free(logic cmd, int unsigned req_size,
                                                    int unsigned addr);
      outcome_type o;
      int unsigned need;
      int unsigned i;
      o = '0;
      if (cmd == CMD_ALLOC) begin
         if (req_size == 0) begin
            o.status = ST_ZERO_SIZE;
         end else begin
            need = ((req_size + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
            o.status = ST_OUT_OF_MEM;
            for (i = 0; i < blk_count; i++)
               if (blk_free[i] && blk_size[i] >= need) break;
            if (i < blk_count) begin
               if (blk_size[i] > need + HEADER_BYTES && blk_count < MAX_BLOCKS) begin
                  for (int unsigned j = blk_count; j > i + 1; j--) begin
                     blk_start[j] = blk_start[j-1];
                     blk_size[j]  = blk_size[j-1];
                     blk_free[j]  = blk_free[j-1];
                  end
                  blk_start[i+1] = blk_start[i] + HEADER_BYTES + need;
                  blk_size[i+1]  = blk_size[i] - need - HEADER_BYTES;
                  blk_free[i+1]  = 1;
                  blk_size[i]    = need;
                  blk_count++;
               end
               blk_free[i]   = 0;
               granted_bytes = sat_sum(granted_bytes, need);
               o.status      = ST_OK;
               o.payload     = ADDR_W'(blk_start[i] + HEADER_BYTES);
               o.bytes       = SIZE_W'(need);
            end
         end
      end else begin
         o.status = ST_BAD_ADDRESS;
         if (addr != 0) begin
            for (i = 0; i < blk_count; i++)
               if (blk_start[i] + HEADER_BYTES == addr) break;
            if (i < blk_count) begin
               if (blk_free[i]) begin
                  o.status = ST_DOUBLE_FREE;
               end else begin
                  blk_free[i]    = 1;
                  released_bytes = sat_sum(released_bytes, blk_size[i]);
                  o.bytes        = SIZE_W'(blk_size[i]);
                  o.status       = ST_OK;
                  // coalesce every run of free neighbors
                  i = 0;
                  while (i + 1 < blk_count) begin
                     if (blk_free[i] && blk_free[i+1]) begin
                        blk_size[i] += HEADER_BYTES + blk_size[i+1];
                        drop_entry(i + 1);
                     end else begin
                        i++;
                     end
                  end
               end
            end
         end
      end
      o.granted  = granted_bytes;
      o.released = released_bytes;
      return o;
   endfunction

   initial begin
      fail_count = 0;
      pending    = 0;
      rebuild_pool(RESET_POOL);
   end

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         rebuild_pool(RESET_POOL);
         outcome_queue.delete();
      end else begin
         // the response leaving this edge belongs to an earlier word
         if (rsp_valid && rsp_ready) begin
            if (outcome_queue.size() == 0) begin
               $error("response word with no request outstanding");
               fail_count++;
            end else begin
               want = outcome_queue.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_payload_address !== want.payload) begin
                  $error("payload_address: expected %0d, got %0d",
                         want.payload, rsp_payload_address);
                  fail_count++;
               end
               if (rsp_block_bytes !== want.bytes) begin
                  $error("block_bytes: expected %0d, got %0d", want.bytes, rsp_block_bytes);
                  fail_count++;
               end
               if (rsp_allocated_total !== want.granted) begin
                  $error("allocated_total: expected %0d, got %0d",
                         want.granted, rsp_allocated_total);
                  fail_count++;
               end
               if (rsp_freed_total !== want.released) begin
                  $error("freed_total: expected %0d, got %0d",
                         want.released, rsp_freed_total);
                  fail_count++;
               end
            end
         end
         if (csr_write_enable)
            rebuild_pool(csr_write_data);
         if (req_valid && req_ready)
            outcome_queue.push_back(allocate_or_free(req_command, req_request_size,
                                                     req_block_address));
      end
      pending = outcome_queue.size();
   end

endmodule

FILE: tb/sv/first_fit_block_allocator_tb.sv
// testbench top for the first-fit block allocator: stimulus, flow control and verdict
`timescale 1ns / 1ps
module first_fit_block_allocator_tb;
   import ffba_pkg::*;

   localparam int IDLE_LIMIT  = 12000;
   localparam int DRAIN_WAIT  = 600;
   localparam int HOLD_CYCLES = 2000;

   logic              clock = 0;
   logic              reset = 1;
   logic              csr_write_enable = 0;
   logic [SIZE_W-1:0] csr_write_data = '0;
   logic              req_valid = 0;
   logic              req_ready;
   logic              req_command = CMD_ALLOC;
   logic [SIZE_W-1:0] req_request_size = '0;
   logic [ADDR_W-1:0] req_block_address = '0;
   logic              rsp_valid;
   logic              rsp_ready = 0;
   logic [2:0]        rsp_status;
   logic [ADDR_W-1:0] rsp_payload_address;
   logic [SIZE_W-1:0] rsp_block_bytes;
   logic [SUM_W-1:0]  rsp_allocated_total;
   logic [SUM_W-1:0]  rsp_freed_total;
   int                fail_count;
   int                pending;

   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int hold_request   = 0;
   int hold_orders    = 0;
   int hold_taken     = 0;
   int idle_cycles    = 0;
   int words_sent     = 0;
   int pool_settings  = 0;
   logic [ADDR_W-1:0] live_blocks[$];
   logic [ADDR_W-1:0] dead_blocks[$];

   first_fit_block_allocator i_dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_ready(req_ready), .req_command(req_command),
      .req_request_size(req_request_size), .req_block_address(req_block_address),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_payload_address(rsp_payload_address), .rsp_block_bytes(rsp_block_bytes),
      .rsp_allocated_total(rsp_allocated_total), .rsp_freed_total(rsp_freed_total)
   );

   first_fit_block_allocator_checker i_checker (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_ready(req_ready), .req_command(req_command),
      .req_request_size(req_request_size), .req_block_address(req_block_address),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_payload_address(rsp_payload_address), .rsp_block_bytes(rsp_block_bytes),
      .rsp_allocated_total(rsp_allocated_total), .rsp_freed_total(rsp_freed_total),
      .fail_count(fail_count), .pending(pending)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // receiver: random stalls, long hold-offs on request, harvest granted addresses
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready && rsp_status == ST_OK && rsp_payload_address != 0)
         live_blocks.push_back(rsp_payload_address);
      if (hold_orders != hold_taken) begin
         rsp_ready    <= 0;
         hold_request <= HOLD_CYCLES - 1;
         hold_taken   <= hold_orders;
      end else if (hold_request > 0) begin
         rsp_ready <= 0;
         hold_request <= hold_request - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_word(logic cmd, int unsigned req_size, int unsigned addr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid         <= 1;
      req_command       <= cmd;
      req_request_size  <= SIZE_W'(req_size);
      req_block_address <= ADDR_W'(addr);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_pool(int unsigned value);
      drain();
      csr_write_enable <= 1;
      csr_write_data   <= SIZE_W'(value);
      @(posedge clock);
      csr_write_enable <= 0;
      live_blocks.delete();
      dead_blocks.delete();
      pool_settings++;
   endtask

   task automatic random_word();
      int r;
      int k;
      logic [ADDR_W-1:0] a;
      r = $urandom_range(99);
      if (r < 55 || live_blocks.size() == 0) begin
         r = $urandom_range(99);
         if (r < 70)      send_word(CMD_ALLOC, $urandom_range(64, 1), 0);
         else if (r < 85) send_word(CMD_ALLOC, $urandom_range(512, 65), $urandom);
         else if (r < 95) send_word(CMD_ALLOC, $urandom_range(4096, 513), 0);
         else if (r < 97) send_word(CMD_ALLOC, 0, $urandom);
         else             send_word(CMD_ALLOC, $urandom_range(8191, 4097), 0);
      end else if (r < 90) begin
         k = $urandom_range(live_blocks.size() - 1);
         a = live_blocks[k];
         live_blocks.delete(k);
         dead_blocks.push_back(a);
         if (dead_blocks.size() > 16) void'(dead_blocks.pop_front());
         send_word(CMD_FREE, $urandom, 32'(a));
      end else if (r < 95 && dead_blocks.size() != 0) begin
         // stale address: double free, or a block that merged away
         send_word(CMD_FREE, 0, 32'(dead_blocks[$urandom_range(dead_blocks.size() - 1)]));
      end else begin
         send_word(CMD_FREE, 0, $urandom_range(1) ? $urandom_range(4095) : 0);
      end
   endtask

   task automatic random_phase(int unsigned pool, int count, int idle_pct,
                               int stall_pct);
      write_pool(pool);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) random_word();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // pool of 1024 after reset
      send_word(CMD_ALLOC, 0, 0);
      send_word(CMD_ALLOC, 1, 0);
      send_word(CMD_ALLOC, 8, 0);
      send_word(CMD_ALLOC, 16, 0);
      send_word(CMD_FREE, 0, 56);
      send_word(CMD_FREE, 0, 56);
      send_word(CMD_FREE, 0, 24);
      send_word(CMD_FREE, 0, 88);
      send_word(CMD_ALLOC, 8191, 'hfff);
      send_word(CMD_ALLOC, 4096, 0);
      send_word(CMD_FREE, 'h1fff, 0);
      send_word(CMD_FREE, 0, 'hfff);
      send_word(CMD_FREE, 0, 25);
      // exact fit takes the whole block, then nothing is left
      send_word(CMD_ALLOC, 1000, 0);
      send_word(CMD_ALLOC, 1, 0);
      send_word(CMD_FREE, 0, 24);
      // remainder of one header or less is not split off
      send_word(CMD_ALLOC, 977, 0);
      send_word(CMD_FREE, 0, 24);
      send_word(CMD_ALLOC, 7, 'h555);
      send_word(CMD_FREE, 0, 'haaa);

      random_phase(4096, 170, 0, 0);
      random_phase(32, 40, 45, 0);
      random_phase(0, 20, 0, 45);
      random_phase(8191, 170, 0, 45);
      random_phase($urandom_range(4095, 33), 150, 22, 22);

      // long receiver hold-off while the sender keeps offering words
      write_pool(1024);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_orders++;
      repeat (60) random_word();
      drain();

      random_phase(4096, 170, 45, 45);
      // many small grants to push the table toward its entry limit
      write_pool(4096);
      send_idle_pct = 0;
      rsp_stall_pct = 10;
      repeat (140) send_word(CMD_ALLOC, $urandom_range(8, 1), 0);
      repeat (40) random_word();

      drain();
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("covered %0d request words over %0d pool settings, alloc and free mixed",
               words_sent, pool_settings);
      $display("idle, stall and long hold-off phases, checker mismatches: %0d", fail_count);
      if (fail_count == 0 && pending == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
